// ----- design/eop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_pkg
// Shared types for the even/odd partition unit: request structs, controller
// states, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package eop_pkg;

  // Input request: one array element plus its end-of-array marker
  typedef struct packed {
    logic signed [31:0] value;
    logic               final_element;
  } in_req_t;

  // Output request: one element of the partitioned array
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_last;
    logic               overflow;
  } out_req_t;

  // Controller states
  typedef enum logic [2:0] {
    S_LOAD,   // take elements into the store
    S_PCHK,   // compare pointers, read both ends
    S_PEVAL,  // test parity at low, start swap if odd
    S_PSWAP,  // second half of the swap, move high down
    S_EREAD,  // read the next element to emit
    S_ELOAD,  // load the output register
    S_EWAIT   // wait for the result to be taken
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;   // input side may accept
    logic part_read;  // read store at low and high
    logic part_adv;   // low pointer up
    logic swap_lo;    // write high entry's value to low
    logic swap_hi;    // write low entry's value to high, high pointer down
    logic emit_read;  // read store at emit index
    logic emit_load;  // load output register
    logic emit_next;  // emit index up
    logic emit_done;  // array finished, clear count and overflow
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic final_fire;  // element with final marker accepted
    logic low_lt_high; // partition not finished
    logic low_odd;     // element read at low is odd
    logic out_taken;   // output register emptied this cycle
    logic out_last;    // element in output register is the last one
  } sts_t;

endpackage

// ----- design/eop_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_ctrl
// Sequencer for load, two-pointer partition and emit phases.
// ----------------------------------------------------------------------------
module eop_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  eop_pkg::sts_t sts_i,
  output eop_pkg::cmd_t cmd_o
);

  eop_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eop_pkg::S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      eop_pkg::S_LOAD: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.final_fire) begin
          state_d = eop_pkg::S_PCHK;
        end
      end
      eop_pkg::S_PCHK: begin
        if (sts_i.low_lt_high) begin
          cmd_o.part_read = 1'b1;
          state_d         = eop_pkg::S_PEVAL;
        end else begin
          state_d = eop_pkg::S_EREAD;
        end
      end
      eop_pkg::S_PEVAL: begin
        if (sts_i.low_odd) begin
          cmd_o.swap_lo = 1'b1;
          state_d       = eop_pkg::S_PSWAP;
        end else begin
          cmd_o.part_adv = 1'b1;
          state_d        = eop_pkg::S_PCHK;
        end
      end
      eop_pkg::S_PSWAP: begin
        cmd_o.swap_hi = 1'b1;
        state_d       = eop_pkg::S_PCHK;
      end
      eop_pkg::S_EREAD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = eop_pkg::S_ELOAD;
      end
      eop_pkg::S_ELOAD: begin
        cmd_o.emit_load = 1'b1;
        state_d         = eop_pkg::S_EWAIT;
      end
      eop_pkg::S_EWAIT: begin
        if (sts_i.out_taken) begin
          if (sts_i.out_last) begin
            cmd_o.emit_done = 1'b1;
            state_d         = eop_pkg::S_LOAD;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = eop_pkg::S_EREAD;
          end
        end
      end
      default: begin
        state_d = eop_pkg::S_LOAD;
      end
    endcase
  end

endmodule

// ----- design/eop_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_dp
// Element store, count, pointers, overflow flag and output register.
// ----------------------------------------------------------------------------
module eop_dp #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  eop_pkg::cmd_t    cmd_i,
  output eop_pkg::sts_t    sts_o,
  input  logic             in_valid_i,
  input  eop_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output eop_pkg::out_req_t out_req_o
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [DATA_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] low_q, low_d, high_q, high_d, idx_q, idx_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  eop_pkg::out_req_t out_q;

  logic          in_fire, full, out_taken;
  logic [63:0]   in_ext, rd_ext;
  logic [DATA_WIDTH-1:0] in_data;
  logic [AW-1:0] rd_a_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  assign in_fire   = in_valid_i & cmd_i.in_ready;
  assign full      = (count_q == CW'(MAX_ELEMENTS));
  assign out_taken = out_valid_q & ~out_stall_i;

  // Input value into store width, zero padded above 32 bits
  assign in_ext  = {32'b0, in_req_i.value};
  assign in_data = in_ext[DATA_WIDTH-1:0];

  // Store write port: load, or one half of a swap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = in_data;
    if (in_fire && !full) begin
      wr_en = 1'b1;
    end else if (cmd_i.swap_lo) begin
      wr_en   = 1'b1;
      wr_addr = low_q;
      wr_data = rd_b_q;
    end else if (cmd_i.swap_hi) begin
      wr_en   = 1'b1;
      wr_addr = high_q;
      wr_data = rd_a_q;
    end
  end

  assign rd_a_addr = cmd_i.emit_read ? idx_q : low_q;

  // Element store: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.part_read || cmd_i.emit_read) begin
      rd_a_q <= mem[rd_a_addr];
    end
    if (cmd_i.part_read) begin
      rd_b_q <= mem[high_q];
    end
  end

  // Count, pointers, emit index, overflow flag
  always_comb begin
    count_d     = count_q;
    low_d       = low_q;
    high_d      = high_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
      if (in_req_i.final_element) begin
        low_d  = '0;
        high_d = full ? AW'(count_q - CW'(1)) : AW'(count_q);
        idx_d  = '0;
      end
    end
    if (cmd_i.part_adv) begin
      low_d = low_q + AW'(1);
    end
    if (cmd_i.swap_hi) begin
      high_d = high_q - AW'(1);
    end
    if (cmd_i.emit_next) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.emit_done) begin
      count_d = '0;
      ovf_d   = 1'b0;
      low_d   = '0;
      high_d  = '0;
    end
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      low_q       <= low_d;
      high_q      <= high_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  assign rd_ext = 64'(rd_a_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q.result_value <= rd_ext[31:0];
      out_q.result_last  <= ((CW'(idx_q) + CW'(1)) == count_q);
      out_q.overflow     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Status to controller
  assign sts_o.final_fire  = in_fire & in_req_i.final_element;
  assign sts_o.low_lt_high = (low_q < high_q);
  assign sts_o.low_odd     = rd_a_q[0];
  assign sts_o.out_taken   = out_taken;
  assign sts_o.out_last    = out_q.result_last;

endmodule

// ----- design/even_odd_partition_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// even_odd_partition_unit
// Loads an array, partitions it even-first with two pointers, emits it.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle until one arrives with final_element set;
// elements beyond MAX_ELEMENTS are dropped and flag overflow on every result
// of that array. No input is taken from then until the last result is taken.
// The partition runs on a store with one write and two read ports: each step
// on an even element passes pointer check and parity test, each swap adds a
// second write state (the swap needs two writes), and a last pointer check
// finishes it. Each result then goes through store read, output register
// load and handoff, and waits there while the output is stalled.
module even_odd_partition_unit #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  eop_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output eop_pkg::out_req_t out_req_o
);

  eop_pkg::cmd_t cmd;
  eop_pkg::sts_t sts;

  eop_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  eop_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  assign in_stall_o = ~cmd.in_ready;

  // No input while a result is pending
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // Last result taken returns to loading
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_req_o.result_last |=> !in_stall_o)
    else $error("input not reopened after last result");

  // At most one store write source per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.in_ready && in_valid_i, cmd.swap_lo, cmd.swap_hi}))
    else $error("store write conflict");

  // A swap's second half always follows its first
  a_swap_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.swap_lo |=> cmd.swap_hi)
    else $error("swap not completed");

endmodule

// ----- tb/tb_even_odd_partition_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_even_odd_partition_unit
// Self-checking bench for the even/odd partition unit.
// ----------------------------------------------------------------------------
// Each accepted element feeds a local copy of the array store. When the final
// element goes in, the bench partitions its copy the way the unit should (low
// pointer over even entries, odd entries swapped to the high end) and queues
// one expected request per stored element. Output requests are matched field
// by field in order. A short table of hand-picked arrays runs first, then
// random arrays of mostly short length, with a few full and overflowing ones,
// under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_even_odd_partition_unit;

  localparam int MAX_EL      = 64;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_ITEMS = 66;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  eop_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  eop_pkg::out_req_t out_req_o;

  even_odd_partition_unit #(
    .MAX_ELEMENTS(MAX_EL),
    .DATA_WIDTH  (32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // Directed row: one element, with a typed expectation for one-element arrays
  typedef struct {
    logic [31:0] value;
    bit          fin;
    bit          has_exp;
    logic [31:0] exp_value;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  dir_row_t dir_tbl [DIR_ROWS] = '{
    // one-element arrays: result is the element itself, marked last
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
    // odd then even: a single swap
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0},
    // negatives and extremes mixed
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b1, 1'b0, 32'h0},
    // all even: no swaps
    '{32'h0000_0004, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // all odd: high pointer walks down to zero
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    // alternating parity
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0006, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0008, 1'b1, 1'b0, 32'h0}
  };

  // Local copy of the unit's array state
  logic [31:0] arr_store [MAX_EL];
  int          arr_count;
  bit          arr_ovf;

  eop_pkg::out_req_t partitioned_q [$];

  int n_errors;
  int n_items;
  int n_arrays;
  int n_ovf_arrays;
  int n_results;
  int longest_array;
  int send_idle_pct;
  int recv_stall_pct;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Store one accepted element; on the final one, partition and queue results
  function automatic void take_element(eop_pkg::in_req_t req, bit queue_it);
    logic [31:0]       tmp;
    int                lo;
    int                hi;
    eop_pkg::out_req_t res;
    if (arr_count < MAX_EL) begin
      arr_store[arr_count] = req.value;
      arr_count++;
    end else begin
      arr_ovf = 1'b1;
    end
    if (!req.final_element) return;

    lo = 0;
    hi = arr_count - 1;
    while (lo < hi) begin
      if (!arr_store[lo][0]) begin
        lo++;
      end else begin
        tmp           = arr_store[lo];
        arr_store[lo] = arr_store[hi];
        arr_store[hi] = tmp;
        hi--;
      end
    end

    if (queue_it) begin
      for (int i = 0; i < arr_count; i++) begin
        res.result_value = arr_store[i];
        res.result_last  = (i == arr_count - 1);
        res.overflow     = arr_ovf;
        partitioned_q.push_back(res);
      end
    end
    n_arrays++;
    if (arr_ovf) n_ovf_arrays++;
    if (arr_count > longest_array) longest_array = arr_count;
    arr_count = 0;
    arr_ovf   = 1'b0;
  endfunction

  // Offer one element, with random idle cycles ahead of it
  task automatic send_element(eop_pkg::in_req_t req, bit queue_it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (in_stall_o);
    take_element(req, queue_it);
    n_items++;
    @(negedge clk_i);
  endtask

  // Hold the input idle until every queued result has been taken
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (partitioned_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h0000_0000;
      3:       v = 32'hFFFF_FFFF;
      4, 5:    v = $urandom_range(15) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver: random stall per cycle
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Output checker
  always @(posedge clk_i) begin : result_check
    eop_pkg::out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (partitioned_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value=%h last=%b ovf=%b",
                                out_req_o.result_value, out_req_o.result_last,
                                out_req_o.overflow));
      end else begin
        want = partitioned_q.pop_front();
        if (out_req_o.result_value !== want.result_value)
          flag_mismatch($sformatf("result_value %h, want %h",
                                  out_req_o.result_value, want.result_value));
        if (out_req_o.result_last !== want.result_last)
          flag_mismatch($sformatf("result_last %b, want %b",
                                  out_req_o.result_last, want.result_last));
        if (out_req_o.overflow !== want.overflow)
          flag_mismatch($sformatf("overflow %b, want %b",
                                  out_req_o.overflow, want.overflow));
      end
    end
  end

  // Watchdog: cycles without any accepted request
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle = 0;
      else
        idle++;
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    eop_pkg::in_req_t  req;
    eop_pkg::out_req_t res;
    int                send_pct [4];
    int                recv_pct [4];
    int                phase_items;
    int                len;
    send_pct = '{0, 81, 0, 17};
    recv_pct = '{0, 0, 81, 17};

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_errors       = 0;
    n_items        = 0;
    n_arrays       = 0;
    n_ovf_arrays   = 0;
    n_results      = 0;
    longest_array  = 0;
    arr_count      = 0;
    arr_ovf        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      req.value         = dir_tbl[r].value;
      req.final_element = dir_tbl[r].fin;
      if (dir_tbl[r].has_exp) begin
        res.result_value = dir_tbl[r].exp_value;
        res.result_last  = 1'b1;
        res.overflow     = 1'b0;
        partitioned_q.push_back(res);
      end
      send_element(req, !dir_tbl[r].has_exp);
    end
    drain_results();

    // Random arrays under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      phase_items    = 0;
      while (phase_items < PHASE_ITEMS) begin
        // first array of some phases is full or overflowing
        if (phase_items == 0 && ph == 1) begin
          len = MAX_EL + 2;
        end else if (phase_items == 0 && ph == 2) begin
          len = MAX_EL;
        end else if (phase_items == 0 && ph == 3) begin
          len = MAX_EL + 6;
        end else begin
          case ($urandom_range(99)) inside
            [0:59]:  len = $urandom_range(8, 1);
            [60:84]: len = $urandom_range(40, 9);
            [85:94]: len = $urandom_range(MAX_EL - 1, 41);
            [95:96]: len = MAX_EL;
            default: len = $urandom_range(MAX_EL + 4, MAX_EL + 1);
          endcase
        end
        for (int k = 0; k < len; k++) begin
          req.value         = pick_value();
          req.final_element = (k == len - 1);
          send_element(req, 1'b1);
        end
        phase_items += len;
      end
      drain_results();
    end

    // Let the unit settle, then check nothing is left
    in_valid_i = 1'b0;
    repeat (50) @(posedge clk_i);
    if (partitioned_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", partitioned_q.size()));

    $display("covered %0d elements in %0d arrays (%0d with dropped elements)",
             n_items, n_arrays, n_ovf_arrays);
    $display("checked %0d results, longest array %0d, four idling mixes",
             n_results, longest_array);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/eop_pkg.sv
design/eop_ctrl.sv
design/eop_dp.sv
design/even_odd_partition_unit.sv
tb/tb_even_odd_partition_unit.sv
